// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/mlf_pkg.sv =====
package mlf_pkg;

   // Field widths fixed by the interface
   localparam int MAC_W  = 48;
   localparam int PORT_W = 3;
   localparam int MASK_W = 8;

   // Default table depth and number of physical ports
   localparam int TABLE_ENTRIES_DEF = 16;
   localparam int PORT_COUNT        = 8;

   // Egress masks are limited to existing ports
   localparam logic [MASK_W-1:0] PORT_LIMIT =
      (PORT_COUNT >= MASK_W) ? {MASK_W{1'b1}} : MASK_W'((1 << PORT_COUNT) - 1);

   localparam logic [MASK_W-1:0] CONN_RESET = 8'hFF;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN
   } state_type;

   // Search status handed from cell to cell along with the token
   typedef struct packed {
      logic token;     // a lookup is passing through this position
      logic src_hit;   // source address already present
      logic free_seen; // an empty entry was found
      logic dst_hit;   // destination address present
   } scan_flags_type;

endpackage

// ===== rtl/mlf_cell.sv =====
module mlf_cell #(
   parameter int TABLE_ENTRIES = mlf_pkg::TABLE_ENTRIES_DEF,
   parameter int CELL_INDEX    = 0
) (
   input  logic                              clock,
   input  logic                              reset,
   // search status from the previous cell
   input  mlf_pkg::scan_flags_type           flags_in,
   input  logic [$clog2(TABLE_ENTRIES)-1:0]  free_idx_in,
   input  logic [$clog2(TABLE_ENTRIES)-1:0]  dst_idx_in,
   input  logic [mlf_pkg::PORT_W-1:0]        dst_port_in,
   // search status to the next cell
   output mlf_pkg::scan_flags_type           flags_out,
   output logic [$clog2(TABLE_ENTRIES)-1:0]  free_idx_out,
   output logic [$clog2(TABLE_ENTRIES)-1:0]  dst_idx_out,
   output logic [mlf_pkg::PORT_W-1:0]        dst_port_out,
   // header under lookup, held by the controller
   input  logic [mlf_pkg::MAC_W-1:0]         look_src,
   input  logic [mlf_pkg::MAC_W-1:0]         look_dst,
   input  logic [mlf_pkg::PORT_W-1:0]        look_port,
   // entry write from the controller
   input  logic                              wr_en,
   input  logic [$clog2(TABLE_ENTRIES)-1:0]  wr_idx,
   input  logic [mlf_pkg::MAC_W-1:0]         wr_mac,
   input  logic [mlf_pkg::PORT_W-1:0]        wr_port
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);

   // One table entry
   logic [mlf_pkg::MAC_W-1:0]  mac_ff;
   logic [mlf_pkg::PORT_W-1:0] port_ff;
   logic                       valid_ff;

   // Registered search status
   mlf_pkg::scan_flags_type    flags_ff, flags_in_nxt;
   logic [IDX_W-1:0]           free_idx_ff, free_idx_in_nxt;
   logic [IDX_W-1:0]           dst_idx_ff, dst_idx_in_nxt;
   logic [mlf_pkg::PORT_W-1:0] dst_port_ff, dst_port_in_nxt;

   logic src_match;
   logic dst_match;
   logic own_write;

   assign src_match = valid_ff && (mac_ff == look_src);
   assign dst_match = valid_ff && (mac_ff == look_dst);
   assign own_write = wr_en && (wr_idx == IDX_W'(CELL_INDEX));

   // Fold this entry into the search status
   always_comb begin
      flags_in_nxt    = flags_in;
      free_idx_in_nxt = free_idx_in;
      dst_idx_in_nxt  = dst_idx_in;
      dst_port_in_nxt = dst_port_in;
      if (src_match) begin
         flags_in_nxt.src_hit = 1'b1;
      end
      if (!flags_in.free_seen && !valid_ff) begin
         flags_in_nxt.free_seen = 1'b1;
         free_idx_in_nxt        = IDX_W'(CELL_INDEX);
      end
      if (!flags_in.dst_hit && dst_match) begin
         flags_in_nxt.dst_hit = 1'b1;
         dst_idx_in_nxt       = IDX_W'(CELL_INDEX);
         dst_port_in_nxt      = port_ff;
      end
   end

   // Status register toward the neighbor
   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in_nxt;
      end
   end

   always_ff @(posedge clock) begin
      free_idx_ff <= free_idx_in_nxt;
      dst_idx_ff  <= dst_idx_in_nxt;
      dst_port_ff <= dst_port_in_nxt;
   end

   // Entry valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (own_write) begin
         valid_ff <= 1'b1;
      end
   end

   // Entry contents: new insert, or port refresh as the token passes a match
   always_ff @(posedge clock) begin
      if (own_write) begin
         mac_ff  <= wr_mac;
         port_ff <= wr_port;
      end else if (flags_in.token && src_match) begin
         port_ff <= look_port;
      end
   end

   assign flags_out    = flags_ff;
   assign free_idx_out = free_idx_ff;
   assign dst_idx_out  = dst_idx_ff;
   assign dst_port_out = dst_port_ff;

endmodule

// ===== rtl/mac_learning_forwarder_top.sv =====
// Learning bridge forwarding table. Each accepted header first learns its
// source address (port refresh on a match, insert into the lowest empty entry,
// or round-robin replacement when the table is full), then looks up the
// destination: a hit gives a one-hot egress mask, a miss floods to all
// connected ports but the ingress one. One header is handled at a time: the
// header is registered, then a search token walks the row of entry cells one
// cell per cycle, then the source is learned and the result formed, and then
// the result moves to the output register. A result still waiting on the
// output holds the next one in that last step. The next header can be
// accepted at the edge after the one that loads the output register, even
// while that result still waits there. connected_ports resets to all ones.
`include "assert_macros.svh"

module mac_learning_forwarder_top #(
   parameter int TABLE_ENTRIES = mlf_pkg::TABLE_ENTRIES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   // request: [47:0] src_mac, [95:48] dst_mac, [98:96] ingress_port, zero pad
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [103:0] req_tdata,
   // response: [7:0] egress_mask
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [7:0]   rsp_tdata,
   // response flags: [0] flooded, [1] learned_new, [2] evicted
   output logic [2:0]   rsp_tuser,
   // connected_ports register write
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [7:0]   csr_data
);

   localparam int IDX_W  = $clog2(TABLE_ENTRIES);
   localparam int MAC_W  = mlf_pkg::MAC_W;
   localparam int PORT_W = mlf_pkg::PORT_W;
   localparam int MASK_W = mlf_pkg::MASK_W;

   mlf_pkg::state_type state_ff, state_in;

   // Header under lookup
   logic [MAC_W-1:0]  req_src_ff;
   logic [MAC_W-1:0]  req_dst_ff;
   logic [PORT_W-1:0] req_port_ff;

   logic [IDX_W-1:0]  ptr_ff;
   logic [MASK_W-1:0] conn_ff;

   // Staged result and output register
   logic [MASK_W-1:0] res_mask_ff;
   logic [2:0]        res_user_ff;
   logic              rsp_tvalid_ff;
   logic [MASK_W-1:0] rsp_mask_ff;
   logic [2:0]        rsp_user_ff;

   // Cell chain wiring
   mlf_pkg::scan_flags_type flags_chain [TABLE_ENTRIES+1];
   logic [IDX_W-1:0]        free_chain  [TABLE_ENTRIES+1];
   logic [IDX_W-1:0]        dsti_chain  [TABLE_ENTRIES+1];
   logic [PORT_W-1:0]       dstp_chain  [TABLE_ENTRIES+1];

   logic              req_accept;
   logic              start_ff;
   logic              scan_done;
   logic              tbl_write;
   logic              load_rsp;
   logic              evict;
   logic [IDX_W-1:0]  wr_idx;
   logic              dst_eq_src;
   logic              dst_hit;
   logic [PORT_W-1:0] hit_port;
   logic [MASK_W-1:0] egress_mask;
   mlf_pkg::scan_flags_type last_flags;

   assign req_accept = req_tvalid && req_tready;
   assign last_flags = flags_chain[TABLE_ENTRIES];

   // Token enters the first cell once the header is registered
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= 1'b0;
      end else begin
         start_ff <= req_accept;
      end
   end

   // token is the top bit of the status, all other flags start clear
   assign flags_chain[0] = {start_ff, 3'b000};
   assign free_chain[0] = '0;
   assign dsti_chain[0] = '0;
   assign dstp_chain[0] = '0;

   for (genvar gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
      mlf_cell #(
         .TABLE_ENTRIES (TABLE_ENTRIES),
         .CELL_INDEX    (gi)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .flags_in     (flags_chain[gi]),
         .free_idx_in  (free_chain[gi]),
         .dst_idx_in   (dsti_chain[gi]),
         .dst_port_in  (dstp_chain[gi]),
         .flags_out    (flags_chain[gi+1]),
         .free_idx_out (free_chain[gi+1]),
         .dst_idx_out  (dsti_chain[gi+1]),
         .dst_port_out (dstp_chain[gi+1]),
         .look_src     (req_src_ff),
         .look_dst     (req_dst_ff),
         .look_port    (req_port_ff),
         .wr_en        (tbl_write),
         .wr_idx       (wr_idx),
         .wr_mac       (req_src_ff),
         .wr_port      (req_port_ff)
      );
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mlf_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = mlf_pkg::ST_SCAN;
            end
         end
         mlf_pkg::ST_SCAN: begin
            if (last_flags.token) begin
               state_in = mlf_pkg::ST_DRAIN;
            end
         end
         mlf_pkg::ST_DRAIN: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               state_in = mlf_pkg::ST_IDLE;
            end
         end
         default: state_in = mlf_pkg::ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      req_tready = 1'b0;
      scan_done  = 1'b0;
      load_rsp   = 1'b0;
      unique case (state_ff)
         mlf_pkg::ST_IDLE:  req_tready = 1'b1;
         mlf_pkg::ST_SCAN:  scan_done  = last_flags.token;
         mlf_pkg::ST_DRAIN: load_rsp   = !rsp_tvalid_ff || rsp_tready;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mlf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Capture the header
   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_src_ff  <= req_tdata[47:0];
         req_dst_ff  <= req_tdata[95:48];
         req_port_ff <= req_tdata[98:96];
      end
   end

   // Learning decision at the end of the scan
   assign evict     = !last_flags.src_hit && !last_flags.free_seen;
   assign wr_idx    = last_flags.free_seen ? free_chain[TABLE_ENTRIES] : ptr_ff;
   assign tbl_write = scan_done && !last_flags.src_hit;

   // Destination as seen after learning: the evicted entry is gone and the
   // source itself is always present
   assign dst_eq_src = (req_dst_ff == req_src_ff);
   assign dst_hit    = dst_eq_src ||
                       (last_flags.dst_hit &&
                        !(evict && (dsti_chain[TABLE_ENTRIES] == ptr_ff)));
   assign hit_port   = dst_eq_src ? req_port_ff : dstp_chain[TABLE_ENTRIES];

   always_comb begin
      if (dst_hit) begin
         egress_mask = (MASK_W'(1) << hit_port) & mlf_pkg::PORT_LIMIT;
      end else begin
         egress_mask = conn_ff & ~(MASK_W'(1) << req_port_ff) & mlf_pkg::PORT_LIMIT;
      end
   end

   // Round-robin replacement pointer
   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
      end else if (scan_done && evict) begin
         if (ptr_ff == IDX_W'(TABLE_ENTRIES - 1)) begin
            ptr_ff <= '0;
         end else begin
            ptr_ff <= ptr_ff + IDX_W'(1);
         end
      end
   end

   // Stage the result
   always_ff @(posedge clock) begin
      if (scan_done) begin
         res_mask_ff <= egress_mask;
         res_user_ff <= {evict, !last_flags.src_hit, !dst_hit};
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_mask_ff <= res_mask_ff;
         rsp_user_ff <= res_user_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_mask_ff;
   assign rsp_tuser  = rsp_user_ff;

   // Configuration register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         conn_ff <= mlf_pkg::CONN_RESET;
      end else if (csr_valid) begin
         conn_ff <= csr_data;
      end
   end

   // Checks
   `ASSERT_IMPLIES(a_token_in_scan, clock, reset, last_flags.token, state_ff == mlf_pkg::ST_SCAN)
   `ASSERT_NEXT(a_ptr_moves, clock, reset, scan_done && evict, ptr_ff != $past(ptr_ff))
   `ASSERT_IMPLIES(a_evict_learns, clock, reset, rsp_tvalid && rsp_tuser[2], rsp_tuser[1])
   `ASSERT_IMPLIES(a_hit_onehot, clock, reset, rsp_tvalid && !rsp_tuser[0], $onehot0(rsp_tdata))

endmodule

// ===== verif/mlf_checker.sv =====
`timescale 1ns / 1ps

// Watches the header, result and link-register channels of the forwarder,
// keeps its own copy of the MAC table and checks every result in order.
module mlf_checker #(
   parameter int TABLE_ENTRIES = mlf_pkg::TABLE_ENTRIES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [103:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [7:0]   rsp_tdata,
   input  logic [2:0]   rsp_tuser,
   input  logic         csr_valid,
   input  logic         csr_ready,
   input  logic [7:0]   csr_data,
   output int           fail_count,
   output int           pending,
   output int           flood_count,
   output int           evict_count
);
   localparam int MAC_W  = mlf_pkg::MAC_W;
   localparam int PORT_W = mlf_pkg::PORT_W;
   localparam int MASK_W = mlf_pkg::MASK_W;

   typedef struct packed {
      logic [MASK_W-1:0] egress_mask;
      logic              flooded;
      logic              learned_new;
      logic              evicted;
   } fwd_result_type;

   // Shadow forwarding table
   logic [MAC_W-1:0]  shadow_mac  [TABLE_ENTRIES];
   logic [PORT_W-1:0] shadow_port [TABLE_ENTRIES];
   bit                shadow_used [TABLE_ENTRIES];
   int unsigned       victim_slot;
   logic [MASK_W-1:0] link_up;

   fwd_result_type forward_due[$];

   initial begin
      fail_count  = 0;
      pending     = 0;
      flood_count = 0;
      evict_count = 0;
   end

   // Learn the source, then look up the destination in the updated table
   function automatic fwd_result_type learn_and_forward(input logic [MAC_W-1:0] src,
                                                        input logic [MAC_W-1:0] dst,
                                                        input logic [PORT_W-1:0] port);
      fwd_result_type r;
      int             slot;
      bit             hit;
      r    = '0;
      slot = -1;
      hit  = 0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (shadow_used[i] && shadow_mac[i] == src) begin
            slot = i;
            break;
         end
      end
      if (slot < 0) begin
         r.learned_new = 1'b1;
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (!shadow_used[i]) begin
               slot = i;
               break;
            end
         end
         // full table: round-robin replacement
         if (slot < 0) begin
            slot        = int'(victim_slot);
            victim_slot = (victim_slot + 1) % TABLE_ENTRIES;
            r.evicted   = 1'b1;
         end
         shadow_mac[slot]  = src;
         shadow_used[slot] = 1'b1;
      end
      shadow_port[slot] = port;

      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (shadow_used[i] && shadow_mac[i] == dst) begin
            r.egress_mask = (MASK_W'(1) << shadow_port[i]) & mlf_pkg::PORT_LIMIT;
            hit = 1'b1;
            break;
         end
      end
      // unknown destination: flood to linked ports but the ingress one
      if (!hit) begin
         r.flooded     = 1'b1;
         r.egress_mask = link_up & ~(MASK_W'(1) << port) & mlf_pkg::PORT_LIMIT;
      end
      return r;
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : monitor
      fwd_result_type got;
      fwd_result_type want;
      if (reset) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) shadow_used[i] = 1'b0;
         victim_slot = 0;
         link_up     = mlf_pkg::CONN_RESET;
         forward_due.delete();
      end else begin
         if (csr_valid && csr_ready) link_up = csr_data;

         if (req_tvalid && req_tready) begin
            want = learn_and_forward(req_tdata[47:0], req_tdata[95:48], req_tdata[98:96]);
            if (want.flooded) flood_count++;
            if (want.evicted) evict_count++;
            forward_due = {forward_due, want};
         end

         if (rsp_tvalid && rsp_tready) begin
            got.egress_mask = rsp_tdata;
            got.flooded     = rsp_tuser[0];
            got.learned_new = rsp_tuser[1];
            got.evicted     = rsp_tuser[2];
            if (forward_due.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h", $time, got);
               fail_count++;
            end else begin
               want = forward_due.pop_front();
               check_field("egress_mask", want.egress_mask, got.egress_mask);
               check_field("flooded", want.flooded, got.flooded);
               check_field("learned_new", want.learned_new, got.learned_new);
               check_field("evicted", want.evicted, got.evicted);
            end
         end
      end
      pending = forward_due.size();
   end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
   localparam int MAC_W  = mlf_pkg::MAC_W;
   localparam int PORT_W = mlf_pkg::PORT_W;
   localparam int MASK_W = mlf_pkg::MASK_W;

   localparam int QUIET_LIMIT = 3000;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_ITEMS = 100;
   localparam int POOL_SIZE   = 20;
   localparam logic [MAC_W-1:0] MAC_A = 48'h0A1B_2C3D_4E5F;
   localparam logic [MAC_W-1:0] MAC_B = 48'hF0E1_D2C3_B4A5;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [103:0] req_tdata  = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [7:0]   rsp_tdata;
   logic [2:0]   rsp_tuser;
   logic         csr_valid  = 1'b0;
   logic         csr_ready;
   logic [7:0]   csr_data   = '0;

   int fail_count, pending, flood_count, evict_count;
   int quiet_cycles = 0;
   int headers_sent = 0;
   int link_writes  = 0;
   bit req_acc      = 1'b0;
   bit csr_acc      = 1'b0;
   bit no_gaps      = 1'b0;
   bit hold_rsp     = 1'b0;

   logic [MAC_W-1:0] mac_pool [POOL_SIZE];

   always #4 clock = ~clock;

   mac_learning_forwarder_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   mlf_checker chk (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .fail_count  (fail_count),
      .pending     (pending),
      .flood_count (flood_count),
      .evict_count (evict_count)
   );

   // Transaction flags for the drivers, plus the stall watchdog
   always @(posedge clock) begin
      req_acc <= req_tvalid && req_tready;
      csr_acc <= csr_valid && csr_ready;
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
         $display("tb NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Result side: random back-pressure, one long hold-off on request
   initial begin : rsp_side
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end
         rsp_tready <= no_gaps || ($urandom_range(99) >= 23);
      end
   end

   function automatic logic [MAC_W-1:0] fresh_mac();
      return MAC_W'({$urandom(), $urandom()});
   endfunction

   task automatic send_header(input logic [MAC_W-1:0] src, input logic [MAC_W-1:0] dst,
                              input logic [PORT_W-1:0] port);
      int gap;
      // idle gaps of random length so they land on every cycle of a lookup
      if (!no_gaps && $urandom_range(99) < 23) begin
         gap = $urandom_range(20, 1);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, port, dst, src};
      do @(negedge clock); while (!req_acc);
      headers_sent++;
   endtask

   task automatic random_header();
      logic [MAC_W-1:0] src;
      logic [MAC_W-1:0] dst;
      int               pick;
      src  = ($urandom_range(3) != 0) ? mac_pool[$urandom_range(POOL_SIZE-1)] : fresh_mac();
      pick = $urandom_range(9);
      if (pick < 6)
         dst = mac_pool[$urandom_range(POOL_SIZE-1)];
      else if (pick == 6)
         dst = src;
      else
         dst = fresh_mac();
      send_header(src, dst, PORT_W'($urandom_range(7)));
   endtask

   // Wait until every expected result has been returned
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic write_links(input logic [MASK_W-1:0] links);
      csr_valid <= 1'b1;
      csr_data  <= links;
      do @(negedge clock); while (!csr_acc);
      csr_valid <= 1'b0;
      link_writes++;
   endtask

   initial begin : stimulus
      logic [MASK_W-1:0] links;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      for (int i = 0; i < POOL_SIZE; i++) mac_pool[i] = fresh_mac();

      // Directed: address extremes, source equal to destination, flood,
      // port refresh, hit on a refreshed port, then fill up and evict
      send_header(48'h0, 48'h0, 3'd0);
      send_header(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 3'd7);
      send_header(MAC_A, MAC_B, 3'd3);
      send_header(MAC_A, MAC_A, 3'd5);
      send_header(MAC_B, MAC_A, 3'd0);
      for (int i = 0; i < 14; i++)
         send_header(48'h0200_0000_0000 + i, 48'h0, PORT_W'(i));
      send_header(48'h0, MAC_A, 3'd6);
      drain();

      // Random phases, each under its own link setting
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0:       links = 8'h00;
            1:       links = 8'hFF;
            2:       links = 8'h5A;
            4:       links = 8'h81;
            default: links = MASK_W'($urandom);
         endcase
         write_links(links);
         for (int i = 0; i < 6; i++) mac_pool[$urandom_range(POOL_SIZE-1)] = fresh_mac();
         no_gaps = (ph == 2);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (ph == 1 && n == 20) hold_rsp = 1'b1;
            random_header();
         end
         drain();
      end
      no_gaps = 1'b0;

      // let any stray result show up before the verdict
      repeat (40) @(negedge clock);
      $display("sent %0d headers under %0d link settings", headers_sent, link_writes);
      $display("predicted %0d floods and %0d evictions", flood_count, evict_count);
      if (fail_count == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
